/* src/pbm_pkg.sv */
package pbm_pkg;

	// Blend mode codes; code 7 passes the base value through
	typedef enum logic [2:0] {
		MODE_NORMAL     = 3'd0,
		MODE_MULTIPLY   = 3'd1,
		MODE_SCREEN     = 3'd2,
		MODE_OVERLAY    = 3'd3,
		MODE_DIFFERENCE = 3'd4,
		MODE_LIGHTEN    = 3'd5,
		MODE_DARKEN     = 3'd6
	} pbm_mode_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_BLEND_MODE    = 2'd0;
	localparam logic [1:0] CFG_OPACITY       = 2'd1;
	localparam logic [1:0] CFG_CHANNELS_USED = 2'd2;

	localparam logic [8:0] OPACITY_FULL  = 9'd256;
	localparam logic [2:0] CHANNELS_INIT = 3'd3;

	// Pipeline depth from accepted pixel to result strobe
	localparam int unsigned LATENCY = 6;

	typedef struct packed {
		logic [2:0] blend_mode;
		logic [8:0] opacity;
		logic [2:0] channels_used;
	} pbm_cfg_t;

	typedef struct packed {
		logic [7:0] base_ch0;
		logic [7:0] base_ch1;
		logic [7:0] base_ch2;
		logic [7:0] base_ch3;
		logic [7:0] top_ch0;
		logic [7:0] top_ch1;
		logic [7:0] top_ch2;
		logic [7:0] top_ch3;
	} pbm_in_t;

	typedef struct packed {
		logic [7:0] out_ch0;
		logic [7:0] out_ch1;
		logic [7:0] out_ch2;
		logic [7:0] out_ch3;
	} pbm_out_t;

endpackage

/* src/pixel_blend_modes_unit.sv */
// Per-channel layer blend (normal, multiply, screen, overlay, difference,
// lighten, darken) with opacity mix, on pixels of up to four 8-bit channels.
// A pixel is taken on every clock where start is high; busy is always low.
// Its result leaves the lane pipeline with done high for exactly one cycle,
// one pixel per clock sustained. The receiver cannot stall the block: there
// is no hold-off on the result side, so each result must be taken in the
// cycle where done is high. Each pixel passes through the six-stage lane
// pipeline: operand select, product, reciprocal multiply for /255, quotient
// correction, opacity products, rounding sum. Write the configuration
// registers only while no pixel is in flight; channels at or above
// channels_used read as zero.
module pixel_blend_modes_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pbm_pkg::pbm_in_t  layers,
	output logic             done,
	output pbm_pkg::pbm_out_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [8:0]       cfg_data
);
	import pbm_pkg::*;

	pbm_cfg_t cfg_q;
	logic [LATENCY-1:0] vld_q;
	logic [3:0] act;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blend_mode    <= MODE_NORMAL;
			cfg_q.opacity       <= OPACITY_FULL;
			cfg_q.channels_used <= CHANNELS_INIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BLEND_MODE:    cfg_q.blend_mode    <= cfg_data[2:0];
				CFG_OPACITY:       cfg_q.opacity       <= cfg_data;
				CFG_CHANNELS_USED: cfg_q.channels_used <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// valid bits travel alongside the lane stages
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start && !busy};
		end
	end

	assign done = vld_q[LATENCY-1];

	// channel enables
	always_comb begin
		act[0] = cfg_q.channels_used > 3'd0;
		act[1] = cfg_q.channels_used > 3'd1;
		act[2] = cfg_q.channels_used > 3'd2;
		act[3] = cfg_q.channels_used > 3'd3;
	end

	pbm_lane u_lane0 (
		.clk(clk), .cfg(cfg_q), .act(act[0]),
		.base(layers.base_ch0), .top(layers.top_ch0), .res(result.out_ch0)
	);
	pbm_lane u_lane1 (
		.clk(clk), .cfg(cfg_q), .act(act[1]),
		.base(layers.base_ch1), .top(layers.top_ch1), .res(result.out_ch1)
	);
	pbm_lane u_lane2 (
		.clk(clk), .cfg(cfg_q), .act(act[2]),
		.base(layers.base_ch2), .top(layers.top_ch2), .res(result.out_ch2)
	);
	pbm_lane u_lane3 (
		.clk(clk), .cfg(cfg_q), .act(act[3]),
		.base(layers.base_ch3), .top(layers.top_ch3), .res(result.out_ch3)
	);

	// every result strobe traces back to an earlier transaction
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 6))
		else $error("done without a matching transaction");

	// no accepted transaction is dropped
	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("accepted transaction produced no result");

endmodule

/* src/pbm_lane.sv */
// One channel of the blend datapath, six register stages
module pbm_lane (
	input  logic            clk,
	input  pbm_pkg::pbm_cfg_t cfg,
	input  logic            act,
	input  logic [7:0]      base,
	input  logic [7:0]      top,
	output logic [7:0]      res
);
	import pbm_pkg::*;

	// stage 1 operand select
	logic [7:0] op_a, op_c, simple;
	logic       dbl, inv, usep;

	logic [7:0] a_s1, c_s1, b_s1, simple_s1;
	logic       dbl_s1, inv_s1, usep_s1;

	logic [16:0] x_s2;
	logic [7:0]  b_s2, simple_s2;
	logic        inv_s2, usep_s2;

	logic [16:0] x_s3;
	logic [8:0]  qe_s3;
	logic [7:0]  b_s3, simple_s3;
	logic        inv_s3, usep_s3;

	logic [7:0]  m_s4, b_s4;

	logic [15:0] pa_s5, pb_s5;

	logic [7:0]  res_s6;

	logic [15:0] prod;
	logic [24:0] recip;
	logic [16:0] qe255, rem;
	logic [8:0]  q;
	logic [7:0]  q8, m;
	logic [8:0]  opc;
	logic [16:0] mix_sum;

	always_comb begin
		op_a   = base;
		op_c   = top;
		dbl    = 1'b0;
		inv    = 1'b0;
		usep   = 1'b0;
		simple = base;
		case (cfg.blend_mode)
			MODE_NORMAL: begin
				simple = top;
			end
			MODE_MULTIPLY: begin
				usep = 1'b1;
			end
			MODE_SCREEN: begin
				op_a = ~base;
				op_c = ~top;
				inv  = 1'b1;
				usep = 1'b1;
			end
			MODE_OVERLAY: begin
				usep = 1'b1;
				dbl  = 1'b1;
				if (base[7]) begin
					op_a = ~base;
					op_c = ~top;
					inv  = 1'b1;
				end
			end
			MODE_DIFFERENCE: begin
				simple = (base > top) ? (base - top) : (top - base);
			end
			MODE_LIGHTEN: begin
				simple = (base > top) ? base : top;
			end
			MODE_DARKEN: begin
				simple = (base < top) ? base : top;
			end
			default: begin
				simple = base;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		a_s1      <= op_a;
		c_s1      <= op_c;
		b_s1      <= base;
		simple_s1 <= simple;
		dbl_s1    <= dbl;
		inv_s1    <= inv;
		usep_s1   <= usep;
	end

	// stage 2: product plus rounding bias
	assign prod = a_s1 * c_s1;

	always_ff @(posedge clk) begin
		x_s2      <= (dbl_s1 ? {prod, 1'b0} : {1'b0, prod}) + 17'd127;
		b_s2      <= b_s1;
		simple_s2 <= simple_s1;
		inv_s2    <= inv_s1;
		usep_s2   <= usep_s1;
	end

	// stage 3: quotient estimate x*257/65536, low by at most one
	assign recip = {x_s2, 8'd0} + {8'd0, x_s2};

	always_ff @(posedge clk) begin
		x_s3      <= x_s2;
		qe_s3     <= recip[24:16];
		b_s3      <= b_s2;
		simple_s3 <= simple_s2;
		inv_s3    <= inv_s2;
		usep_s3   <= usep_s2;
	end

	// stage 4: one correction step, then invert for screen-type forms or take the simple result
	always_comb begin
		qe255 = {qe_s3, 8'd0} - {8'd0, qe_s3};
		rem   = x_s3 - qe255;
		q     = qe_s3 + {8'd0, (rem >= 17'd255)};
		q8    = q[7:0];
		m     = usep_s3 ? (inv_s3 ? (8'd255 - q8) : q8) : simple_s3;
	end

	always_ff @(posedge clk) begin
		m_s4 <= m;
		b_s4 <= b_s3;
	end

	// stage 5: opacity weights; full opacity and above reduce to m*256
	assign opc = OPACITY_FULL - cfg.opacity;

	always_ff @(posedge clk) begin
		if (!cfg.opacity[8]) begin
			pa_s5 <= b_s4 * opc[8:0];
			pb_s5 <= m_s4 * cfg.opacity[7:0];
		end else begin
			pa_s5 <= {m_s4, 8'd0};
			pb_s5 <= '0;
		end
	end

	// stage 6: round half up and mask inactive channel
	assign mix_sum = {1'b0, pa_s5} + {1'b0, pb_s5} + 17'd128;

	always_ff @(posedge clk) begin
		res_s6 <= act ? mix_sum[15:8] : 8'd0;
	end

	assign res = res_s6;

endmodule

/* dv/pixel_blend_modes_unit_tb.sv */
module pixel_blend_modes_unit_tb;
	import pbm_pkg::*;

	// Mode code outside the enum: passes the base value through
	localparam logic [2:0] MODE_PASS_BASE = 3'd7;
	// Register index with no register behind it
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	pbm_in_t    layers;
	logic       done;
	pbm_out_t   result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;

	// Shadow copy of the configuration registers
	logic [2:0] mode_reg;
	logic [8:0] opacity_reg;
	logic [2:0] nchan_reg;

	pbm_out_t   expected_pixels[$];
	int         mismatches;
	int         idle_pct;

	pixel_blend_modes_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.layers    (layers),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// One channel: blend by mode, then opacity mix toward the base
	function automatic logic [7:0] blend_channel(int unsigned b, int unsigned t);
		int unsigned m;
		case (mode_reg)
			MODE_NORMAL:     m = t;
			MODE_MULTIPLY:   m = (b * t + 127) / 255;
			MODE_SCREEN:     m = 255 - ((255 - b) * (255 - t) + 127) / 255;
			MODE_OVERLAY:    m = (b < 128) ? (2 * b * t + 127) / 255
			                               : 255 - (2 * (255 - b) * (255 - t) + 127) / 255;
			MODE_DIFFERENCE: m = (b > t) ? b - t : t - b;
			MODE_LIGHTEN:    m = (b > t) ? b : t;
			MODE_DARKEN:     m = (b < t) ? b : t;
			default:         m = b;
		endcase
		if (opacity_reg < OPACITY_FULL)
			m = (b * (OPACITY_FULL - opacity_reg) + m * opacity_reg + 128) >> 8;
		return m[7:0];
	endfunction

	function automatic pbm_out_t blend_pixel(pbm_in_t px);
		logic [7:0] b[4];
		logic [7:0] t[4];
		logic [7:0] r[4];
		pbm_out_t   o;
		b = '{px.base_ch0, px.base_ch1, px.base_ch2, px.base_ch3};
		t = '{px.top_ch0, px.top_ch1, px.top_ch2, px.top_ch3};
		// channels at or above the count read zero; counts above four cover all
		for (int i = 0; i < 4; i++)
			r[i] = (i < nchan_reg) ? blend_channel(b[i], t[i]) : 8'd0;
		o.out_ch0 = r[0];
		o.out_ch1 = r[1];
		o.out_ch2 = r[2];
		o.out_ch3 = r[3];
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Track register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_reg    <= MODE_NORMAL;
			opacity_reg <= OPACITY_FULL;
			nchan_reg   <= CHANNELS_INIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BLEND_MODE:    mode_reg    <= cfg_data[2:0];
				CFG_OPACITY:       opacity_reg <= cfg_data;
				CFG_CHANNELS_USED: nchan_reg   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Predict each accepted pixel transaction
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			expected_pixels.push_back(blend_pixel(layers));
	end

	// Check each result strobe against the oldest prediction
	always @(posedge clk) begin
		pbm_out_t want;
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected result", result, 0);
			end else begin
				want = expected_pixels.pop_front();
				if (result.out_ch0 !== want.out_ch0)
					report_mismatch("out_ch0", result.out_ch0, want.out_ch0);
				if (result.out_ch1 !== want.out_ch1)
					report_mismatch("out_ch1", result.out_ch1, want.out_ch1);
				if (result.out_ch2 !== want.out_ch2)
					report_mismatch("out_ch2", result.out_ch2, want.out_ch2);
				if (result.out_ch3 !== want.out_ch3)
					report_mismatch("out_ch3", result.out_ch3, want.out_ch3);
			end
		end
	end

	// Send one pixel, with an optional idle burst first; start stays high
	task automatic send_pixel(pbm_in_t px);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		start  <= 1'b1;
		layers <= px;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Stop sending and wait until every result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Write all registers back to back; valid drops only after the last one
	task automatic set_config(logic [8:0] mode_data, logic [8:0] opac_data,
			logic [8:0] chan_data, bit poke_unused);
		logic [1:0] idx[4];
		logic [8:0] dat[4];
		int         n;
		idx = '{CFG_BLEND_MODE, CFG_OPACITY, CFG_CHANNELS_USED, CFG_UNUSED};
		dat = '{mode_data, opac_data, chan_data, 9'($urandom_range(0, 511))};
		n = poke_unused ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= dat[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'd127;
			3:       return 8'd128;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pbm_in_t rand_pixel();
		pbm_in_t px;
		px.base_ch0 = rand_byte();
		px.base_ch1 = rand_byte();
		px.base_ch2 = rand_byte();
		px.base_ch3 = rand_byte();
		px.top_ch0  = rand_byte();
		px.top_ch1  = rand_byte();
		px.top_ch2  = rand_byte();
		px.top_ch3  = rand_byte();
		return px;
	endfunction

	function automatic logic [8:0] rand_opacity();
		case ($urandom_range(0, 5))
			0:       return 9'd0;
			1:       return OPACITY_FULL;
			2:       return 9'($urandom_range(257, 511));
			3:       return $urandom_range(0, 1) ? 9'd1 : 9'd255;
			default: return 9'($urandom_range(0, 255));
		endcase
	endfunction

	// Reset values: normal mode, full opacity, three channels
	task automatic test_reset_defaults();
		send_pixel('0);
		send_pixel('{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd1});
		drain();
	endtask

	// Every mode code, including the pass-through one, at the operand extremes
	// and across the overlay split between 127 and 128
	task automatic test_each_mode();
		for (int m = 0; m < 8; m++) begin
			set_config(9'(m), OPACITY_FULL, 9'd4, 1'b0);
			send_pixel('{8'd0, 8'd127, 8'd128, 8'd255, 8'd255, 8'd255, 8'd0, 8'd128});
			send_pixel('{8'd255, 8'd128, 8'd127, 8'd0, 8'd0, 8'd127, 8'd200, 8'd255});
			drain();
		end
	endtask

	// Opacity zero and above full, zero and too many channels, unused index
	task automatic test_opacity_and_channels();
		set_config(9'(MODE_OVERLAY), 9'd0, 9'd4, 1'b0);
		send_pixel('{8'd10, 8'd200, 8'd128, 8'd255, 8'd250, 8'd3, 8'd77, 8'd0});
		drain();
		set_config(9'(MODE_MULTIPLY), 9'd300, 9'd4, 1'b1);
		send_pixel('{8'd200, 8'd255, 8'd1, 8'd90, 8'd200, 8'd255, 8'd254, 8'd91});
		drain();
		set_config(9'(MODE_SCREEN), 9'd128, 9'd0, 1'b0);
		send_pixel('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
		drain();
		set_config(9'(MODE_PASS_BASE), 9'd1, 9'h1FF, 1'b1);
		send_pixel('{8'd1, 8'd2, 8'd254, 8'd255, 8'd255, 8'd0, 8'd3, 8'd4});
		drain();
	endtask

	// Random pixels over random settings; the last phases run without gaps
	task automatic test_random_pixels();
		for (int ph = 0; ph < 30; ph++) begin
			set_config(9'($urandom_range(0, 511)), rand_opacity(),
				9'($urandom_range(0, 511)), $urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0:       idle_pct = 0;
				1:       idle_pct = 10;
				2:       idle_pct = 30;
				default: idle_pct = 60;
			endcase
			if (ph >= 26)
				idle_pct = 0;
			repeat (52) send_pixel(rand_pixel());
			drain();
		end
	endtask

	initial begin
		mismatches = 0;
		idle_pct   = 0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		layers    <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_each_mode();
		test_opacity_and_channels();
		test_random_pixels();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

/* pixel_blend_modes_unit.f */
src/pbm_pkg.sv
src/pbm_lane.sv
src/pixel_blend_modes_unit.sv
dv/pixel_blend_modes_unit_tb.sv
